/* design/i2c_master_transaction_macros.svh */
// Assertion macros for the I2C master transaction block.
// Included by i2cm_seq, which checks its own logic; no other dependencies.
`ifndef I2C_MASTER_TRANSACTION_MACROS_SVH
`define I2C_MASTER_TRANSACTION_MACROS_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle
`define I2CM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c master check failed");
// Antecedent implies consequent in the next cycle
`define I2CM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c master check failed");
`else
`define I2CM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define I2CM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/i2cm_pkg.sv */
// Shared types and codes of the I2C master transaction block.
// No dependencies; used by the channel interfaces and all modules.
package i2cm_pkg;

  // Operation codes of a request
  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Which byte is on the bus
  localparam logic [1:0] ST_DEV_W = 2'd0;
  localparam logic [1:0] ST_REG   = 2'd1;
  localparam logic [1:0] ST_DEV_R = 2'd2;
  localparam logic [1:0] ST_DATA  = 2'd3;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd3;
  localparam logic [7:0] DIR_CLR_MASK    = 8'hFE;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

  // One tick request
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] operation;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       write_byte_valid;
    logic       sda_in;
  } in_item_t;

  // One tick result
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       byte_request;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       done_res;
    logic       status;
    logic       acked;
  } out_item_t;

endpackage

/* design/i2cm_if.sv */
// Valid/ready channel interfaces for tick requests and tick results.
// Depends on i2cm_pkg.
interface i2cm_in_if;
  import i2cm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface i2cm_out_if;
  import i2cm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* design/i2cm_seq.sv */
// Bus phase sequencer: one tick per advance, registered tick result.
// Depends on i2cm_pkg and i2c_master_transaction_macros.svh.
`include "i2c_master_transaction_macros.svh"

module i2cm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  i2cm_pkg::in_item_t  item,
  input  logic [7:0]          phase_ticks,
  output i2cm_pkg::out_item_t result_r
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_HI, PH_START_FALL, PH_TX_LOW, PH_TX_HIGH,
    PH_TXACK_LOW, PH_TXACK_HIGH, PH_RX_LOW, PH_RX_HIGH, PH_RXACK_LOW,
    PH_RXACK_HIGH, PH_RS_LOW, PH_STOP_LOW, PH_STOP_HIGH, PH_STOP_RISE,
    PH_WAIT_BYTE
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] dev_r, dev_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic [1:0] op_r, op_nxt;
  logic [1:0] stage_r, stage_nxt;
  logic       failed_r, failed_nxt;
  out_item_t  result_nxt;

  logic [7:0] period;
  logic       tick_end;
  logic [7:0] rx_shift;
  logic [3:0] bit_inc;

  assign period   = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign tick_end = ({1'b0, tick_r} + 9'd1) >= {1'b0, period};
  assign rx_shift = {shift_r[6:0], item.sda_in};
  assign bit_inc  = bit_r + 4'd1;

  // Decode bus levels, then advance the phase
  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    left_nxt   = left_r;
    dev_nxt    = dev_r;
    reg_nxt    = reg_r;
    op_nxt     = op_r;
    stage_nxt  = stage_r;
    failed_nxt = failed_r;

    result_nxt           = '0;
    result_nxt.scl_level = 1'b1;
    result_nxt.sda_level = 1'b1;
    result_nxt.busy_res  = (phase_r != PH_IDLE);

    // Drive levels for the current phase
    case (phase_r)
      PH_START_HI: begin
        result_nxt.sda_drive = 1'b1;
      end
      PH_START_FALL: begin
        result_nxt.sda_drive = 1'b1;
        result_nxt.sda_level = 1'b0;
      end
      PH_TX_LOW: begin
        result_nxt.scl_level = 1'b0;
        result_nxt.sda_drive = 1'b1;
        result_nxt.sda_level = shift_r[7];
      end
      PH_TX_HIGH: begin
        result_nxt.sda_drive = 1'b1;
        result_nxt.sda_level = shift_r[7];
      end
      PH_TXACK_LOW, PH_RX_LOW: begin
        result_nxt.scl_level = 1'b0;
      end
      PH_RXACK_LOW: begin
        result_nxt.scl_level = 1'b0;
        result_nxt.sda_drive = 1'b1;
        result_nxt.sda_level = (left_r == 8'd0);
      end
      PH_RXACK_HIGH: begin
        result_nxt.sda_drive = 1'b1;
        result_nxt.sda_level = (left_r == 8'd0);
      end
      PH_RS_LOW: begin
        result_nxt.scl_level = 1'b0;
        result_nxt.sda_drive = 1'b1;
      end
      PH_STOP_LOW: begin
        result_nxt.scl_level = 1'b0;
        result_nxt.sda_drive = 1'b1;
        result_nxt.sda_level = 1'b0;
      end
      PH_STOP_HIGH: begin
        result_nxt.sda_drive = 1'b1;
        result_nxt.sda_level = 1'b0;
      end
      PH_STOP_RISE: begin
        result_nxt.sda_drive = 1'b1;
      end
      PH_WAIT_BYTE: begin
        result_nxt.scl_level    = 1'b0;
        result_nxt.sda_drive    = 1'b1;
        result_nxt.sda_level    = 1'b0;
        result_nxt.byte_request = 1'b1;
      end
      default: begin
      end
    endcase

    // Count ticks within a timed phase
    if (phase_r != PH_IDLE && phase_r != PH_WAIT_BYTE) begin
      tick_nxt = tick_end ? 8'd0 : tick_r + 8'd1;
    end

    if (phase_r == PH_IDLE) begin
      // Take a new transaction; operation 3 is dropped
      if (item.cmd_valid && item.operation <= OP_WRITE) begin
        op_nxt     = item.operation;
        dev_nxt    = item.device_address;
        reg_nxt    = item.register_address;
        left_nxt   = (item.operation == OP_READ && item.byte_count == 8'd0) ?
                     8'd1 : item.byte_count;
        stage_nxt  = ST_DEV_W;
        failed_nxt = 1'b0;
        tick_nxt   = 8'd0;
        phase_nxt  = PH_START_HI;
      end
    end else if (phase_r == PH_WAIT_BYTE) begin
      // Hold the bus until a write byte arrives
      if (item.write_byte_valid) begin
        left_nxt  = left_r - 8'd1;
        tick_nxt  = 8'd0;
        shift_nxt = item.write_byte;
        bit_nxt   = 4'd0;
        phase_nxt = PH_TX_LOW;
      end
    end else if (tick_end) begin
      case (phase_r)
        PH_START_HI: phase_nxt = PH_START_FALL;
        PH_START_FALL: begin
          shift_nxt = (stage_r == ST_DEV_R) ? (dev_r | 8'h01) : (dev_r & DIR_CLR_MASK);
          bit_nxt   = 4'd0;
          phase_nxt = PH_TX_LOW;
        end
        PH_TX_LOW: phase_nxt = PH_TX_HIGH;
        PH_TX_HIGH: begin
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_inc;
          phase_nxt = (bit_inc >= BITS_PER_BYTE) ? PH_TXACK_LOW : PH_TX_LOW;
        end
        PH_TXACK_LOW: phase_nxt = PH_TXACK_HIGH;
        PH_TXACK_HIGH: begin
          if (item.sda_in) begin
            failed_nxt = 1'b1;
            phase_nxt  = PH_STOP_LOW;
          end else if (stage_r == ST_DEV_W) begin
            if (op_r == OP_PROBE) begin
              phase_nxt = PH_STOP_LOW;
            end else begin
              stage_nxt = ST_REG;
              shift_nxt = reg_r;
              bit_nxt   = 4'd0;
              phase_nxt = PH_TX_LOW;
            end
          end else if (stage_r == ST_REG && op_r == OP_READ) begin
            stage_nxt = ST_DEV_R;
            phase_nxt = PH_RS_LOW;
          end else if (stage_r == ST_DEV_R) begin
            bit_nxt   = 4'd0;
            shift_nxt = 8'd0;
            phase_nxt = PH_RX_LOW;
          end else begin
            // Register address or data byte sent: next byte or stop
            stage_nxt = ST_DATA;
            phase_nxt = (left_r == 8'd0) ? PH_STOP_LOW : PH_WAIT_BYTE;
          end
        end
        PH_RX_LOW: phase_nxt = PH_RX_HIGH;
        PH_RX_HIGH: begin
          shift_nxt = rx_shift;
          bit_nxt   = bit_inc;
          if (bit_inc >= BITS_PER_BYTE) begin
            result_nxt.read_valid = 1'b1;
            result_nxt.read_data  = rx_shift;
            result_nxt.read_last  = (left_r <= 8'd1);
            left_nxt  = (left_r != 8'd0) ? left_r - 8'd1 : 8'd0;
            phase_nxt = PH_RXACK_LOW;
          end else begin
            phase_nxt = PH_RX_LOW;
          end
        end
        PH_RXACK_LOW: phase_nxt = PH_RXACK_HIGH;
        PH_RXACK_HIGH: begin
          if (left_r == 8'd0) begin
            phase_nxt = PH_STOP_LOW;
          end else begin
            bit_nxt   = 4'd0;
            shift_nxt = 8'd0;
            phase_nxt = PH_RX_LOW;
          end
        end
        PH_RS_LOW: phase_nxt = PH_START_HI;
        PH_STOP_LOW: phase_nxt = PH_STOP_HIGH;
        PH_STOP_HIGH: phase_nxt = PH_STOP_RISE;
        PH_STOP_RISE: begin
          result_nxt.done_res = 1'b1;
          result_nxt.status   = failed_r;
          result_nxt.acked    = (op_r == OP_PROBE) && !failed_r;
          phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Hold state and the tick result; advance only on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= 8'd0;
      bit_r    <= 4'd0;
      shift_r  <= 8'd0;
      left_r   <= 8'd0;
      dev_r    <= 8'd0;
      reg_r    <= 8'd0;
      op_r     <= OP_PROBE;
      stage_r  <= ST_DEV_W;
      failed_r <= 1'b0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      left_r   <= left_nxt;
      dev_r    <= dev_nxt;
      reg_r    <= reg_nxt;
      op_r     <= op_nxt;
      stage_r  <= stage_nxt;
      failed_r <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  `I2CM_ASSERT_IMP(a_bit_range, clk, rst_n, 1'b1, bit_r <= BITS_PER_BYTE)
  `I2CM_ASSERT_IMP(a_wait_write, clk, rst_n, phase_r == PH_WAIT_BYTE, op_r == OP_WRITE)
  `I2CM_ASSERT_IMP(a_devr_read, clk, rst_n, stage_r == ST_DEV_R, op_r == OP_READ)
  `I2CM_ASSERT_NXT(a_done_idle, clk, rst_n,
    advance && result_nxt.done_res, phase_r == PH_IDLE && result_r.done_res)

endmodule

/* design/i2c_master_transaction.sv */
// Top level of the I2C master transaction block: channels, config, staging.
// Depends on i2cm_pkg, i2cm_in_if, i2cm_out_if and i2cm_seq.
//
//  channel  dir  handshake        request / result
//  in_ch    in   valid/ready      one bus tick: command, write byte, sampled SDA
//  out_ch   out  valid/ready      one bus tick: SCL/SDA drive, read byte, done
//  cfg_*    in   write enable     phase_ticks (ticks per SCL half-phase)
//
// One request per clock while the result side is not stalled; a request passes through
// the input register, then the result register, before its tick result is valid.
// Reset (rst_n low, synchronous) puts the sequencer idle and phase_ticks at 3.
// A stalled result holds in the result register; in_ch.ready stays high while
// the input register is empty or moving on in the same cycle.
module i2c_master_transaction (
  input  logic       clk,
  input  logic       rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import i2cm_pkg::*;

  in_item_t   in_item_r;
  logic       in_valid_r;
  logic       out_valid_r;
  logic [7:0] phase_ticks_r;
  logic       advance;

  // Move a request into the sequencer when the result slot frees up
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  // Input register and result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_ch.data;
    end
  end

  i2cm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item        (in_item_r),
    .phase_ticks (phase_ticks_r),
    .result_r    (out_ch.data)
  );

  assign out_ch.valid = out_valid_r;

endmodule

/* sim/testbench.sv */
// Testbench for the I2C master transaction block: drives one bus tick per request and
// checks every tick result against a tick-by-tick model of the bus sequencer.
// Depends on i2cm_pkg, i2cm_in_if, i2cm_out_if and i2c_master_transaction.
module testbench;
  import i2cm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NO_NACK = -1;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned RANDOM_TICKS = 600;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_HI, PH_START_FALL, PH_TX_LOW, PH_TX_HIGH, PH_TXACK_LOW,
    PH_TXACK_HIGH, PH_RX_LOW, PH_RX_HIGH, PH_RXACK_LOW, PH_RXACK_HIGH, PH_RS_LOW,
    PH_STOP_LOW, PH_STOP_HIGH, PH_STOP_RISE, PH_WAIT_BYTE
  } bus_phase_t;

  // Bus sequencer model plus the queue of tick results still to come
  class tick_scoreboard;
    logic [7:0] phase_ticks;
    bus_phase_t phase;
    logic [7:0] tick_cnt;
    logic [3:0] bit_cnt;
    logic [7:0] shift_reg;
    logic [7:0] bytes_left;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [1:0] held_op;
    logic [1:0] stage;
    bit         nacked;
    out_item_t  expected_ticks[$];
    int unsigned errors;

    function new();
      phase_ticks = PHASE_TICKS_RST;
      phase = PH_IDLE;
      tick_cnt = '0;
      bit_cnt = '0;
      shift_reg = '0;
      bytes_left = '0;
      dev_addr = '0;
      reg_addr = '0;
      held_op = OP_PROBE;
      stage = ST_DEV_W;
      nacked = 0;
      errors = 0;
    endfunction

    // Zero ticks behave as one
    function logic [8:0] half_period();
      return (phase_ticks == 8'd0) ? 9'd1 : {1'b0, phase_ticks};
    endfunction

    function void load_byte(logic [7:0] value);
      shift_reg = value;
      bit_cnt = '0;
      phase = PH_TX_LOW;
    endfunction

    function void next_write();
      stage = ST_DATA;
      phase = (bytes_left == 8'd0) ? PH_STOP_LOW : PH_WAIT_BYTE;
    endfunction

    function out_item_t predict_tick(in_item_t rq);
      out_item_t  r;
      bus_phase_t p;
      bit         fin;
      r = '0;
      r.scl_level = 1'b1;
      r.sda_level = 1'b1;
      p = phase;
      r.busy_res = (p != PH_IDLE);

      // Bus levels follow the phase at the start of the tick
      case (p)
        PH_START_HI: r.sda_drive = 1'b1;
        PH_START_FALL: begin
          r.sda_drive = 1'b1;
          r.sda_level = 1'b0;
        end
        PH_TX_LOW: begin
          r.scl_level = 1'b0;
          r.sda_drive = 1'b1;
          r.sda_level = shift_reg[7];
        end
        PH_TX_HIGH: begin
          r.sda_drive = 1'b1;
          r.sda_level = shift_reg[7];
        end
        PH_TXACK_LOW, PH_RX_LOW: r.scl_level = 1'b0;
        PH_RXACK_LOW: begin
          r.scl_level = 1'b0;
          r.sda_drive = 1'b1;
          r.sda_level = (bytes_left == 8'd0);
        end
        PH_RXACK_HIGH: begin
          r.sda_drive = 1'b1;
          r.sda_level = (bytes_left == 8'd0);
        end
        PH_RS_LOW: begin
          r.scl_level = 1'b0;
          r.sda_drive = 1'b1;
        end
        PH_STOP_LOW: begin
          r.scl_level = 1'b0;
          r.sda_drive = 1'b1;
          r.sda_level = 1'b0;
        end
        PH_STOP_HIGH: begin
          r.sda_drive = 1'b1;
          r.sda_level = 1'b0;
        end
        PH_STOP_RISE: r.sda_drive = 1'b1;
        PH_WAIT_BYTE: begin
          r.scl_level = 1'b0;
          r.sda_drive = 1'b1;
          r.sda_level = 1'b0;
          r.byte_request = 1'b1;
        end
        default: ;
      endcase

      // Advance the half-phase timer
      fin = 0;
      if (p != PH_IDLE && p != PH_WAIT_BYTE) begin
        if ({1'b0, tick_cnt} + 9'd1 >= half_period()) begin
          fin = 1;
          tick_cnt = '0;
        end else begin
          tick_cnt = tick_cnt + 8'd1;
        end
      end

      if (p == PH_IDLE) begin
        if (rq.cmd_valid && rq.operation <= OP_WRITE) begin
          held_op = rq.operation;
          dev_addr = rq.device_address;
          reg_addr = rq.register_address;
          bytes_left = (rq.operation == OP_READ && rq.byte_count == 8'd0) ? 8'd1
                                                                         : rq.byte_count;
          stage = ST_DEV_W;
          nacked = 0;
          tick_cnt = '0;
          phase = PH_START_HI;
        end
      end else if (p == PH_WAIT_BYTE) begin
        if (rq.write_byte_valid) begin
          bytes_left = bytes_left - 8'd1;
          tick_cnt = '0;
          load_byte(rq.write_byte);
        end
      end else if (fin) begin
        case (p)
          PH_START_HI: phase = PH_START_FALL;
          PH_START_FALL:
            load_byte((stage == ST_DEV_R) ? (dev_addr | 8'h01) : (dev_addr & DIR_CLR_MASK));
          PH_TX_LOW: phase = PH_TX_HIGH;
          PH_TX_HIGH: begin
            shift_reg = shift_reg << 1;
            bit_cnt = bit_cnt + 4'd1;
            phase = (bit_cnt >= BITS_PER_BYTE) ? PH_TXACK_LOW : PH_TX_LOW;
          end
          PH_TXACK_LOW: phase = PH_TXACK_HIGH;
          PH_TXACK_HIGH: begin
            if (rq.sda_in) begin
              nacked = 1;
              phase = PH_STOP_LOW;
            end else begin
              case (stage)
                ST_DEV_W: begin
                  if (held_op == OP_PROBE) begin
                    phase = PH_STOP_LOW;
                  end else begin
                    stage = ST_REG;
                    load_byte(reg_addr);
                  end
                end
                ST_REG: begin
                  if (held_op == OP_READ) begin
                    stage = ST_DEV_R;
                    phase = PH_RS_LOW;
                  end else begin
                    next_write();
                  end
                end
                ST_DEV_R: begin
                  bit_cnt = '0;
                  shift_reg = '0;
                  phase = PH_RX_LOW;
                end
                default: next_write();
              endcase
            end
          end
          PH_RX_LOW: phase = PH_RX_HIGH;
          PH_RX_HIGH: begin
            shift_reg = {shift_reg[6:0], rq.sda_in};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= BITS_PER_BYTE) begin
              r.read_valid = 1'b1;
              r.read_data = shift_reg;
              r.read_last = (bytes_left <= 8'd1);
              if (bytes_left != 8'd0) bytes_left = bytes_left - 8'd1;
              phase = PH_RXACK_LOW;
            end else begin
              phase = PH_RX_LOW;
            end
          end
          PH_RXACK_LOW: phase = PH_RXACK_HIGH;
          PH_RXACK_HIGH: begin
            if (bytes_left == 8'd0) begin
              phase = PH_STOP_LOW;
            end else begin
              bit_cnt = '0;
              shift_reg = '0;
              phase = PH_RX_LOW;
            end
          end
          PH_RS_LOW: phase = PH_START_HI;
          PH_STOP_LOW: phase = PH_STOP_HIGH;
          PH_STOP_HIGH: phase = PH_STOP_RISE;
          PH_STOP_RISE: begin
            r.done_res = 1'b1;
            r.status = nacked;
            r.acked = (held_op == OP_PROBE) && !nacked;
            phase = PH_IDLE;
          end
          default: phase = PH_IDLE;
        endcase
      end
      return r;
    endfunction

    function void note_request(in_item_t rq);
      expected_ticks.push_back(predict_tick(rq));
    endfunction

    function void compare_field(string fname, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_ticks.size() == 0) begin
        errors++;
        $display("%0t: unexpected tick result, expected none actual %0h", $time, got);
        return;
      end
      want = expected_ticks.pop_front();
      compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
      compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
      compare_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
      compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      compare_field("byte_request", 8'(want.byte_request), 8'(got.byte_request));
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
      compare_field("read_last", 8'(want.read_last), 8'(got.read_last));
      compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("acked", 8'(want.acked), 8'(got.acked));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;
  logic [15:0] stall_step = '0;
  int unsigned cycle_count = 0;
  int unsigned txn_ticks = 0;
  int burst_left = 0;
  tick_scoreboard board;

  i2cm_in_if req_ch();
  i2cm_out_if res_ch();

  i2c_master_transaction uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(req_ch),
    .out_ch(res_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result side on a rotating pattern: open, light, periodic, heavy
  always @(posedge clk) begin
    stall_step <= stall_step + 16'd1;
    case (stall_step[9:8])
      2'd0: res_ch.ready <= 1'b1;
      2'd1: res_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2: res_ch.ready <= (stall_step[2:0] != 3'd0) && (stall_step[2:0] != 3'd3);
      default: res_ch.ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // Check every accepted tick result
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) board.check_result(res_ch.data);
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("i2c_master_transaction verification failed");
      $finish;
    end
  end

  function automatic in_item_t random_tick();
    in_item_t t;
    t.cmd_valid = 1'($urandom_range(0, 1));
    t.operation = 2'($urandom_range(0, 3));
    t.device_address = 8'($urandom_range(0, 255));
    t.register_address = 8'($urandom_range(0, 255));
    t.byte_count = 8'($urandom_range(0, 255));
    t.write_byte = 8'($urandom_range(0, 255));
    t.write_byte_valid = 1'($urandom_range(0, 1));
    t.sda_in = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Send one request, with bursts and random gaps between them
  task automatic send_tick(input in_item_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= t;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(t);
    burst_left--;
    txn_ticks++;
  endtask

  // Run one transaction to its end, answering as the slave would
  task automatic run_txn(input logic [1:0] op, input logic [7:0] dev, input logic [7:0] regad,
                         input logic [7:0] count, input int nack_at, input int byte_lag);
    in_item_t t;
    int ack_num;
    int wait_num;
    ack_num = 0;
    wait_num = 0;
    t = random_tick();
    t.cmd_valid = 1'b1;
    t.operation = op;
    t.device_address = dev;
    t.register_address = regad;
    t.byte_count = count;
    send_tick(t);
    while (board.phase != PH_IDLE) begin
      t = random_tick();
      // Hold back the write byte for a while
      if (board.phase == PH_WAIT_BYTE) begin
        t.write_byte_valid = (wait_num >= byte_lag);
        wait_num++;
      end else begin
        wait_num = 0;
      end
      // Answer on the tick where the acknowledge is sampled
      if (board.phase == PH_TXACK_HIGH &&
          {1'b0, board.tick_cnt} + 9'd1 >= board.half_period()) begin
        t.sda_in = (ack_num == nack_at);
        ack_num++;
      end
      send_tick(t);
    end
  endtask

  // Write phase_ticks once the pipeline has drained
  task automatic set_phase_ticks(input logic [7:0] value);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (board.expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.phase_ticks = value;
  endtask

  initial begin
    in_item_t idle_tick;
    logic [1:0] op;
    logic [7:0] count;
    int nack_at;
    int unsigned goal;
    board = new();
    rst_n <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed transactions at the reset rate
    run_txn(OP_PROBE, 8'hFF, 8'h00, 8'h00, NO_NACK, 0);
    run_txn(OP_PROBE, 8'h00, 8'hFF, 8'hFF, 0, 0);
    run_txn(OP_UNUSED, 8'h42, 8'h42, 8'h02, NO_NACK, 0);
    run_txn(OP_READ, 8'hA5, 8'h00, 8'h00, NO_NACK, 0);

    // Fastest rate: reads, writes and a NACK at byte positions 1 to 3
    set_phase_ticks(8'd1);
    run_txn(OP_READ, 8'h00, 8'hFF, 8'h03, NO_NACK, 0);
    run_txn(OP_READ, 8'h3C, 8'h11, 8'h02, 1, 0);
    run_txn(OP_READ, 8'hC3, 8'h22, 8'hFF, 2, 0);
    run_txn(OP_WRITE, 8'h5A, 8'h81, 8'h00, NO_NACK, 0);
    run_txn(OP_WRITE, 8'hFE, 8'h7F, 8'h02, NO_NACK, 5);
    run_txn(OP_WRITE, 8'h01, 8'h80, 8'h03, 3, 1);
    run_txn(OP_WRITE, 8'h99, 8'h66, 8'h01, 1, 0);
    run_txn(OP_WRITE, 8'h10, 8'h20, 8'hFF, 2, 0);
    run_txn(OP_READ, 8'hA0, 8'h10, 8'h04, NO_NACK, 0);
    run_txn(OP_WRITE, 8'hA0, 8'h10, 8'h04, NO_NACK, 0);

    // Zero ticks behave as one
    set_phase_ticks(8'd0);
    run_txn(OP_PROBE, 8'h6E, 8'h00, 8'h00, NO_NACK, 0);
    run_txn(OP_WRITE, 8'h6E, 8'h44, 8'h02, NO_NACK, 2);

    // Random transactions under random rates
    goal = txn_ticks + RANDOM_TICKS;
    while (txn_ticks < goal) begin
      case ($urandom_range(0, 9))
        0: set_phase_ticks(8'd0);
        1: set_phase_ticks(8'($urandom_range(4, 5)));
        default: set_phase_ticks(8'($urandom_range(1, 3)));
      endcase
      repeat ($urandom_range(2, 4)) begin
        if (txn_ticks < goal) begin
          // Idle noise without a command
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              idle_tick = random_tick();
              idle_tick.cmd_valid = 1'b0;
              send_tick(idle_tick);
            end
          end
          op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
          count = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(4, 6))
                                              : 8'($urandom_range(0, 3));
          nack_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4)) : NO_NACK;
          run_txn(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), count,
                  nack_at, int'($urandom_range(0, 3)));
        end
      end
    end

    // Drain and settle
    req_ch.valid <= 1'b0;
    while (board.expected_ticks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.expected_ticks.size() == 0) begin
      $display("i2c_master_transaction verification clean");
    end else begin
      $display("i2c_master_transaction verification failed");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+design
design/i2cm_pkg.sv
design/i2cm_if.sv
design/i2cm_seq.sv
design/i2c_master_transaction.sv
sim/testbench.sv
